### rtl/gradient_orientation_cell_histogram_top_defines.svh
// Assertion macros for the gradient orientation cell histogram block.
// Used by the port checker; expects clk and rst_n in scope.
`ifndef GRADIENT_ORIENTATION_CELL_HISTOGRAM_TOP_DEFINES_SVH
`define GRADIENT_ORIENTATION_CELL_HISTOGRAM_TOP_DEFINES_SVH

// Check a property on every edge outside reset.
`define HOG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included.
`define HOG_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/hog_pkg.sv
// Shared types and constants of the gradient orientation cell histogram.
// No dependencies.
`default_nettype none
package hog_pkg;

  localparam int CELL_SIZE_DEF = 8;
  localparam int MAX_CELLS_DEF = 64;
  localparam int BINS          = 8;
  localparam int ACC_W         = 22;
  localparam int PIX_W         = 8;
  localparam int CA_W          = 6;
  localparam int CR_W          = 10;
  localparam int BIN_W         = 3;
  localparam int CFG_DATA_W    = 10;

  typedef enum logic [0:0] {
    CFG_CELLS_ACROSS = 1'b0,
    CFG_CELL_ROWS    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [PIX_W-1:0] above_pixel;
    logic [PIX_W-1:0] below_pixel;
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
  } hog_in_t;

  typedef struct packed {
    logic [CR_W-1:0]  hist_row;
    logic [CA_W-1:0]  cell_column;
    logic [BIN_W-1:0] bin;
    logic [ACC_W-1:0] bin_value;
    logic             last;
  } hog_out_t;

  // One memory row: all bins of one cell.
  typedef logic [BINS-1:0][ACC_W-1:0] row_t;

  typedef struct packed {
    logic            cap0;  // take the first cell row
    logic            cap1;  // take the second cell row
    logic            go;    // start the burst
    logic            two;   // burst covers two cells
    logic [CR_W-1:0] hrow;
    logic [CA_W-1:0] col;
  } emit_ctl_t;

endpackage
`default_nettype wire

### rtl/gradient_orientation_cell_histogram_top.sv
// Gradient orientation cell histogram, 8 bins, bilinear cell weighting.
// Each input beat carries the four neighbours of one pixel in raster order; the
// block cannot take a new beat while the last one is still in S1, set by the two
// read-modify-write passes (the pixel's cell, then the cell to its right) that
// each bank memory port makes per pixel. The last pixel of a cell on the final
// pixel row of a cell row also waits until the previous burst has left the
// buffer. Such a pixel produces a burst of 8 result beats (16 at the end of the
// row), one per cycle while out_stall is low. Accumulators live in two memories,
// one per cell-row bank, one row of 8 bins per cell; a valid bit per row makes
// bank and frame clears take effect at once, so there is no clearing pass.
`default_nettype none
module gradient_orientation_cell_histogram_top #(
  parameter int CELL_SIZE = hog_pkg::CELL_SIZE_DEF,
  parameter int MAX_CELLS = hog_pkg::MAX_CELLS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire hog_pkg::hog_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output hog_pkg::hog_out_t                       out_data,
  input  wire logic                               cfg_we,
  input  wire hog_pkg::cfg_idx_t                  cfg_index,
  input  wire logic [hog_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import hog_pkg::*;

  localparam int CW        = $clog2(MAX_CELLS);
  localparam int IXW       = $clog2(CELL_SIZE);
  localparam int KW        = $clog2(2 * CELL_SIZE);
  localparam int WXW       = PIX_W + KW;
  localparam int WW        = PIX_W + 2 * KW;
  localparam int ROW_W     = BINS * ACC_W;
  localparam int CELLS_LIM = (MAX_CELLS - 1 < 63) ? MAX_CELLS - 1 : 63;

  typedef struct packed {
    hog_in_t         pix;
    logic [CA_W-1:0] c;
    logic [IXW-1:0]  ix;
    logic [IXW-1:0]  iy;
    logic [CR_W-1:0] crow;
    logic            bank;
    logic            emit;
    logic            emit2;
    logic            rowclr;
    logic            frmclr;
  } s1_t;

  typedef struct packed {
    logic [CA_W-1:0]  c;
    logic             bank;
    logic [BIN_W-1:0] idx;
    logic [WXW-1:0]   wx0;
    logic [WXW-1:0]   wx1;
    logic [KW-1:0]    ky0;
    logic [KW-1:0]    ky1;
    logic             emit;
    logic             emit2;
    logic             rowclr;
    logic             frmclr;
    logic [CR_W-1:0]  hrow;
  } stg_t;

  // configuration
  logic [CA_W-1:0] cells_r;
  logic [CR_W-1:0] rows_r;
  logic [CA_W-1:0] cells_eff;
  logic [CR_W-1:0] rows_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_r <= CA_W'(1);
      rows_r  <= CR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CELLS_ACROSS: cells_r <= cfg_wdata[CA_W-1:0];
        CFG_CELL_ROWS:    rows_r  <= cfg_wdata[CR_W-1:0];
        default:          ;
      endcase
    end
  end

  assign cells_eff = (cells_r == '0) ? CA_W'(1) :
                     (cells_r > CA_W'(CELLS_LIM)) ? CA_W'(CELLS_LIM) : cells_r;
  assign rows_eff  = (rows_r == '0) ? CR_W'(1) : rows_r;

  // scan position, advanced on every accepted beat
  logic [CA_W-1:0] c_r, c_nxt, ce;
  logic [IXW-1:0]  ix_r, ix_nxt, ixe;
  logic [IXW-1:0]  iy_r, iy_nxt, iye;
  logic [CR_W-1:0] crow_r, crow_nxt, crowe;
  logic            bank_r, bank_nxt;
  logic            row_end, last_cell, rowclr, frmclr, emit_pos;

  localparam logic [IXW-1:0] LAST_I = IXW'(CELL_SIZE - 1);

  always_comb begin
    // saturate a position left beyond the frame by a register change
    if (c_r >= cells_eff) begin
      ce  = cells_eff - CA_W'(1);
      ixe = LAST_I;
    end else begin
      ce  = c_r;
      ixe = ix_r;
    end
    if (crow_r >= rows_eff) begin
      crowe = rows_eff - CR_W'(1);
      iye   = LAST_I;
    end else begin
      crowe = crow_r;
      iye   = iy_r;
    end
    last_cell = ce == cells_eff - CA_W'(1);
    row_end   = ixe == LAST_I && last_cell;
    emit_pos  = ixe == LAST_I && iye == LAST_I;
    rowclr    = row_end && iye == LAST_I;
    frmclr    = rowclr && crowe == rows_eff - CR_W'(1);

    c_nxt    = ce;
    ix_nxt   = ixe + IXW'(1);
    iy_nxt   = iye;
    crow_nxt = crowe;
    bank_nxt = bank_r;
    if (ixe == LAST_I) begin
      ix_nxt = '0;
      c_nxt  = ce + CA_W'(1);
    end
    if (row_end) begin
      c_nxt = '0;
      if (iye == LAST_I) begin
        iy_nxt   = '0;
        crow_nxt = crowe + CR_W'(1);
        bank_nxt = ~bank_r;
      end else begin
        iy_nxt = iye + IXW'(1);
      end
      if (frmclr) begin
        crow_nxt = '0;
        bank_nxt = 1'b0;
      end
    end
  end

  // pipeline: S1 computes weights and reads cell c, S2 updates c and reads
  // c+1, S3 updates c+1 and applies the item's bank clears
  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r;
  stg_t s2_r, s3_r, s2_nxt;
  logic accept, emit_busy, emit_hold;

  assign emit_hold = emit_busy || (s2_v_r && s2_r.emit) || (s3_v_r && s3_r.emit);
  assign in_stall  = s1_v_r || (emit_pos && emit_hold);
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r    <= '0;
      ix_r   <= '0;
      iy_r   <= '0;
      crow_r <= '0;
      bank_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      if (accept) begin
        c_r    <= c_nxt;
        ix_r   <= ix_nxt;
        iy_r   <= iy_nxt;
        crow_r <= crow_nxt;
        bank_r <= bank_nxt;
      end
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.pix    <= in_data;
      s1_r.c      <= ce;
      s1_r.ix     <= ixe;
      s1_r.iy     <= iye;
      s1_r.crow   <= crowe;
      s1_r.bank   <= bank_r;
      s1_r.emit   <= emit_pos;
      s1_r.emit2  <= emit_pos && last_cell;
      s1_r.rowclr <= rowclr;
      s1_r.frmclr <= frmclr;
    end
    s2_r <= s2_nxt;
    s3_r <= s2_r;
  end

  // S1: magnitude, orientation bin and column weights
  logic [8:0]       dx, dy, ndx, ndy, sum;
  logic [7:0]       adx, ady, mx, mn, mag;
  logic [BIN_W-1:0] idx;
  logic [KW-1:0]    kx0, kx1;

  always_comb begin
    dx  = {1'b0, s1_r.pix.right_pixel} - {1'b0, s1_r.pix.left_pixel};
    dy  = {1'b0, s1_r.pix.below_pixel} - {1'b0, s1_r.pix.above_pixel};
    ndx = 9'd0 - dx;
    ndy = 9'd0 - dy;
    adx = dx[8] ? ndx[7:0] : dx[7:0];
    ady = dy[8] ? ndy[7:0] : dy[7:0];
    mx  = (adx > ady) ? adx : ady;
    mn  = (adx > ady) ? ady : adx;
    sum = {1'b0, mx} + ((9'({1'b0, mn}) + 9'd1) >> 1);
    mag = (sum > 9'd255) ? 8'd255 : sum[7:0];
    idx = (ady > adx) ? BIN_W'(0) : BIN_W'(1);
    if (dy[8] || dy == '0) begin
      idx = BIN_W'(BINS / 2 - 1) - idx;
    end
    if (dx[8] || dx == '0) begin
      idx = BIN_W'(BINS - 1) - idx;
    end
    kx0 = KW'(2 * CELL_SIZE - 1) - KW'({s1_r.ix, 1'b0});
    kx1 = KW'({s1_r.ix, 1'b1});

    s2_nxt.c      = s1_r.c;
    s2_nxt.bank   = s1_r.bank;
    s2_nxt.idx    = idx;
    s2_nxt.wx0    = WXW'(mag) * WXW'(kx0);
    s2_nxt.wx1    = WXW'(mag) * WXW'(kx1);
    s2_nxt.ky0    = KW'(2 * CELL_SIZE - 1) - KW'({s1_r.iy, 1'b0});
    s2_nxt.ky1    = KW'({s1_r.iy, 1'b1});
    s2_nxt.emit   = s1_r.emit;
    s2_nxt.emit2  = s1_r.emit2;
    s2_nxt.rowclr = s1_r.rowclr;
    s2_nxt.frmclr = s1_r.frmclr;
    s2_nxt.hrow   = s1_r.crow;
  end

  // S2/S3 share one update path; they never hold items in the same cycle
  stg_t                 act;
  logic [CA_W-1:0]      wcell;
  logic [CW-1:0]        waddr, raddr;
  logic [WXW-1:0]       wx;
  logic                 we, clr_here;
  logic [1:0][MAX_CELLS-1:0] vld_r, vld_nxt;
  logic [ROW_W-1:0]     rdata [2];
  row_t                 newrow [2];
  row_t                 base;
  logic [KW-1:0]        ky;
  logic [WW-1:0]        w;

  assign act      = s3_v_r ? s3_r : s2_r;
  assign wcell    = s3_v_r ? s3_r.c + CA_W'(1) : s2_r.c;
  assign waddr    = CW'(wcell);
  assign wx       = s3_v_r ? s3_r.wx1 : s2_r.wx0;
  assign we       = s2_v_r || s3_v_r;
  assign clr_here = s3_v_r ? s3_r.emit2 : s2_r.emit;
  assign raddr    = s1_v_r ? CW'(s1_r.c) : CW'(s2_r.c + CA_W'(1));

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      ky   = (1'(p) == act.bank) ? act.ky0 : act.ky1;
      w    = WW'(wx) * WW'(ky);
      base = vld_r[p][waddr] ? row_t'(rdata[p]) : '0;
      newrow[p] = base;
      newrow[p][act.idx] = base[act.idx] + ACC_W'(w);
    end
  end

  for (genvar g = 0; g < 2; g++) begin : g_bank
    hog_ram #(
      .DEPTH (MAX_CELLS),
      .WIDTH (ROW_W)
    ) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr),
      .wdata   (ROW_W'(newrow[g])),
      .raddr   (raddr),
      .rdata_r (rdata[g])
    );
  end

  // row valid bits: set on write, drop when emitted or when a bank clears
  always_comb begin
    vld_nxt = vld_r;
    if (we) begin
      for (int p = 0; p < 2; p++) begin
        vld_nxt[p][waddr] = !(clr_here && 1'(p) == act.bank);
      end
    end
    if (s3_v_r && s3_r.rowclr) begin
      vld_nxt[s3_r.bank] = '0;
    end
    if (s3_v_r && s3_r.frmclr) begin
      vld_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // finished cells go to the burst buffer
  emit_ctl_t ectl;

  always_comb begin
    ectl.cap0 = s2_v_r && s2_r.emit;
    ectl.cap1 = s3_v_r && s3_r.emit2;
    ectl.go   = s3_v_r && s3_r.emit;
    ectl.two  = s3_r.emit2;
    ectl.hrow = s3_r.hrow;
    ectl.col  = s3_r.c;
  end

  hog_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ectl),
    .row       (newrow[act.bank]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .busy      (emit_busy)
  );

endmodule
`default_nettype wire

### rtl/hog_ram.sv
// One bank of cell rows: synchronous memory, one write and one read port.
// Read data is registered; a same-cycle write to the read row is passed through.
`default_nettype none
module hog_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 176
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && waddr == raddr) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/hog_emit.sv
// Burst buffer for finished cells: holds up to two cell rows and plays them
// out one bin per beat through an output register. Uses hog_pkg.
`default_nettype none
module hog_emit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire hog_pkg::emit_ctl_t  ctl,
  input  wire hog_pkg::row_t       row,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output hog_pkg::hog_out_t        out_data,
  output logic                     busy
);
  import hog_pkg::*;

  row_t            buf0_r, buf1_r;
  logic            act_r, act_nxt;
  logic [3:0]      ptr_r, ptr_nxt;
  logic            two_r;
  logic [CR_W-1:0] hrow_r;
  logic [CA_W-1:0] col_r;
  logic            ov_r, ov_nxt;
  hog_out_t        od_r, od_nxt;
  logic            load, fin;
  row_t            sel;

  assign load = act_r && (!ov_r || !out_stall);
  assign fin  = ptr_r == (two_r ? 4'd15 : 4'd7);
  assign sel  = ptr_r[3] ? buf1_r : buf0_r;

  always_comb begin
    act_nxt = act_r;
    ptr_nxt = ptr_r;
    ov_nxt  = ov_r;
    od_nxt  = od_r;
    if (!out_stall) begin
      ov_nxt = 1'b0;
    end
    if (load) begin
      ov_nxt             = 1'b1;
      od_nxt.hist_row    = hrow_r;
      od_nxt.cell_column = col_r + CA_W'(ptr_r[3]);
      od_nxt.bin         = ptr_r[2:0];
      od_nxt.bin_value   = sel[ptr_r[2:0]];
      od_nxt.last        = fin;
      ptr_nxt            = ptr_r + 4'd1;
      if (fin) begin
        act_nxt = 1'b0;
      end
    end
    if (ctl.go) begin
      act_nxt = 1'b1;
      ptr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
      ptr_r <= '0;
    end else begin
      act_r <= act_nxt;
      ov_r  <= ov_nxt;
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    if (ctl.cap0) begin
      buf0_r <= row;
    end
    if (ctl.cap1) begin
      buf1_r <= row;
    end
    if (ctl.go) begin
      two_r  <= ctl.two;
      hrow_r <= ctl.hrow;
      col_r  <= ctl.col;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign busy      = act_r;

endmodule
`default_nettype wire

### rtl/hog_checker.sv
// Port checker for the gradient orientation cell histogram, bound to the top.
// Uses hog_pkg and the assertion macros of the defines header.
`include "gradient_orientation_cell_histogram_top_defines.svh"
`default_nettype none
module hog_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire hog_pkg::hog_out_t out_data
);
  import hog_pkg::*;

  `HOG_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_valid, "result beat right after reset")
  `HOG_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled beat changed")
  `HOG_ASSERT(a_last_bin, out_valid && out_data.last |-> out_data.bin == BIN_W'(BINS - 1), "burst ends off the last bin")
  `HOG_ASSERT(a_burst_seq, out_valid && !out_stall && !out_data.last |=> out_valid && out_data.bin == BIN_W'($past(out_data.bin) + BIN_W'(1)), "burst gap or bin out of order")

endmodule

bind gradient_orientation_cell_histogram_top hog_checker u_hog_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
